/* sv/oal_pkg.sv */
// oal_pkg: request codes, status codes, sequencer states and the result record
// shared by the ordered array list engine modules
// no dependencies
package oal_pkg;

    typedef enum logic [2:0] {
        ACT_INSERT_AT    = 3'd0,
        ACT_INSERT_LAST  = 3'd1,
        ACT_DELETE_FIRST = 3'd2,
        ACT_DELETE_AT    = 3'd3,
        ACT_DELETE_LAST  = 3'd4,
        ACT_SEARCH       = 3'd5,
        ACT_READ         = 3'd6,
        ACT_MODIFY       = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_WAIT,
        S_WRITE,
        S_DONE
    } t_state;

    typedef struct packed {
        t_status     status;
        logic        found;
        logic [3:0]  found_position;
        logic [31:0] read_value;
        logic [4:0]  count;
    } t_result;

endpackage

/* sv/oal_ram.sv */
// oal_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module oal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/oal_seq.sv */
// oal_seq: request sequencer, entry count and the shift/compare loop over the entry RAM
// depends on oal_pkg and oal_ram
module oal_seq #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [2:0]       i_action,
    input  logic [3:0]       i_position,
    input  logic [31:0]      i_value,
    output logic             o_busy,
    output logic             o_done,
    input  logic             i_take,
    output oal_pkg::t_result o_result
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam int PW = (CW > 4) ? CW : 4;

    oal_pkg::t_state  r_state, n_state;
    oal_pkg::t_action r_act, n_act;
    oal_pkg::t_result r_res, n_res;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_k, n_k;
    logic [AW-1:0]    r_posa, n_posa;
    logic [EW-1:0]    r_val, n_val;

    oal_pkg::t_action w_act_in;
    logic [PW-1:0]    w_pos_ext;
    logic [PW-1:0]    w_cnt_ext;
    logic [PW:0]      w_pos_inc;
    logic             w_full;
    logic             w_empty;
    logic [CW-1:0]    w_k_dec;
    logic [CW:0]      w_k_inc;
    logic [CW:0]      w_k_inc2;
    logic [CW:0]      w_cnt_wide;
    logic [CW+3:0]    w_k_wide;
    logic [CW+4:0]    w_cnt5_wide;
    logic [EW+31:0]   w_rd_wide;

    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [EW-1:0]    w_wdata;
    logic             w_re;
    logic [AW-1:0]    w_raddr;
    logic [EW-1:0]    w_rdata;

    oal_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_act_in    = oal_pkg::t_action'(i_action);
    assign w_pos_ext   = PW'(i_position);
    assign w_cnt_ext   = PW'(r_count);
    assign w_pos_inc   = (PW + 1)'(i_position) + (PW + 1)'(1);
    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_empty     = (r_count == '0);
    assign w_k_dec     = r_k - CW'(1);
    assign w_k_inc     = {1'b0, r_k} + (CW + 1)'(1);
    assign w_k_inc2    = {1'b0, r_k} + (CW + 1)'(2);
    assign w_cnt_wide  = {1'b0, r_count};
    assign w_k_wide    = {4'd0, r_k};
    assign w_cnt5_wide = {5'd0, r_count};
    assign w_rd_wide   = {32'd0, w_rdata};

    always_comb begin
        case (r_act)
            oal_pkg::ACT_INSERT_AT:    w_raddr = w_k_dec[AW-1:0];
            oal_pkg::ACT_DELETE_FIRST: w_raddr = w_k_inc[AW-1:0];
            oal_pkg::ACT_DELETE_AT:    w_raddr = w_k_inc[AW-1:0];
            oal_pkg::ACT_SEARCH:       w_raddr = r_k[AW-1:0];
            default:                   w_raddr = r_posa;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_act   = r_act;
        n_res   = r_res;
        n_count = r_count;
        n_k     = r_k;
        n_posa  = r_posa;
        n_val   = r_val;
        w_we    = 1'b0;
        w_waddr = r_k[AW-1:0];
        w_wdata = w_rdata;
        w_re    = 1'b0;
        o_done  = 1'b0;

        case (r_state)
            oal_pkg::S_IDLE: begin
                if (i_start) begin
                    n_act  = w_act_in;
                    n_val  = i_value[EW-1:0];
                    n_posa = w_pos_ext[AW-1:0];
                    n_k    = w_pos_ext[CW-1:0];
                    n_res  = '{status: oal_pkg::ST_OK, found: 1'b0, found_position: 4'd0,
                               read_value: 32'd0, count: 5'd0};
                    n_state = oal_pkg::S_DONE;
                    case (w_act_in)
                        oal_pkg::ACT_INSERT_AT: begin
                            if (w_full) begin
                                n_res.status = oal_pkg::ST_FULL;
                            end else if (w_pos_ext > w_cnt_ext) begin
                                n_res.status = oal_pkg::ST_RANGE;
                            end else begin
                                n_k     = r_count;
                                n_state = (w_pos_ext == w_cnt_ext) ? oal_pkg::S_WRITE
                                                                   : oal_pkg::S_RD;
                            end
                        end
                        oal_pkg::ACT_INSERT_LAST: begin
                            if (w_full) begin
                                n_res.status = oal_pkg::ST_FULL;
                            end else begin
                                n_posa  = r_count[AW-1:0];
                                n_state = oal_pkg::S_WRITE;
                            end
                        end
                        oal_pkg::ACT_DELETE_FIRST: begin
                            n_k = '0;
                            if (w_empty) begin
                                n_res.status = oal_pkg::ST_EMPTY;
                            end else if (r_count > CW'(1)) begin
                                n_state = oal_pkg::S_RD;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        oal_pkg::ACT_DELETE_AT: begin
                            if (w_empty) begin
                                n_res.status = oal_pkg::ST_EMPTY;
                            end else if (w_pos_ext >= w_cnt_ext) begin
                                n_res.status = oal_pkg::ST_RANGE;
                            end else if (w_pos_inc < (PW + 1)'(r_count)) begin
                                n_state = oal_pkg::S_RD;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        oal_pkg::ACT_DELETE_LAST: begin
                            if (w_empty) begin
                                n_res.status = oal_pkg::ST_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        oal_pkg::ACT_SEARCH: begin
                            n_k = '0;
                            if (!w_empty) begin
                                n_state = oal_pkg::S_RD;
                            end
                        end
                        oal_pkg::ACT_READ, oal_pkg::ACT_MODIFY: begin
                            if (w_empty) begin
                                n_res.status = oal_pkg::ST_EMPTY;
                            end else if (w_pos_ext >= w_cnt_ext) begin
                                n_res.status = oal_pkg::ST_RANGE;
                            end else begin
                                n_state = (w_act_in == oal_pkg::ACT_READ) ? oal_pkg::S_RD
                                                                          : oal_pkg::S_WRITE;
                            end
                        end
                        default: begin
                            n_state = oal_pkg::S_DONE;
                        end
                    endcase
                end
            end
            oal_pkg::S_RD: begin
                w_re    = 1'b1;
                n_state = oal_pkg::S_WAIT;
            end
            oal_pkg::S_WAIT: begin
                n_state = oal_pkg::S_DONE;
                case (r_act)
                    oal_pkg::ACT_INSERT_AT: begin
                        // move one entry up
                        w_we    = 1'b1;
                        n_k     = w_k_dec;
                        n_state = (w_k_dec == CW'(r_posa)) ? oal_pkg::S_WRITE
                                                           : oal_pkg::S_RD;
                    end
                    oal_pkg::ACT_DELETE_FIRST, oal_pkg::ACT_DELETE_AT: begin
                        // move one entry down
                        w_we = 1'b1;
                        n_k  = w_k_inc[CW-1:0];
                        if (w_k_inc2 < w_cnt_wide) begin
                            n_state = oal_pkg::S_RD;
                        end else begin
                            n_count = r_count - CW'(1);
                        end
                    end
                    oal_pkg::ACT_SEARCH: begin
                        if (w_rdata == r_val) begin
                            n_res.found          = 1'b1;
                            n_res.found_position = w_k_wide[3:0];
                        end else begin
                            n_k = w_k_inc[CW-1:0];
                            if (w_k_inc < w_cnt_wide) begin
                                n_state = oal_pkg::S_RD;
                            end
                        end
                    end
                    default: begin
                        n_res.read_value = w_rd_wide[31:0];
                    end
                endcase
            end
            oal_pkg::S_WRITE: begin
                w_we    = 1'b1;
                w_waddr = r_posa;
                w_wdata = r_val;
                if (r_act == oal_pkg::ACT_INSERT_AT || r_act == oal_pkg::ACT_INSERT_LAST) begin
                    n_count = r_count + CW'(1);
                end
                n_state = oal_pkg::S_DONE;
            end
            oal_pkg::S_DONE: begin
                o_done = 1'b1;
                if (i_take) begin
                    n_state = oal_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = oal_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= oal_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act  <= n_act;
        r_res  <= n_res;
        r_k    <= n_k;
        r_posa <= n_posa;
        r_val  <= n_val;
    end

    assign o_busy = (r_state != oal_pkg::S_IDLE);

    always_comb begin
        o_result       = r_res;
        o_result.count = w_cnt5_wide[4:0];
    end

endmodule

/* sv/ordered_array_list_engine_unit.sv */
// ordered_array_list_engine_unit: top level, request/result handshakes and result register
// depends on oal_pkg and oal_seq
//
//  channel   direction  valid          stall          payload
//  request   in         i_in_valid     o_in_stall     i_action, i_position, i_value
//  result    out        o_out_valid    i_out_stall    o_status, o_found, o_found_position,
//                                                     o_read_value, o_count
//
// a request is decoded and handed off, and every entry moved, compared or read goes
// through the single read port of the entry ram, then a final write for inserts and modify
// insert_at moves each entry from position up to the end, search reads entries up to the hit
// reset clears the entry count and the control state; entries need no clearing
// a finished result waits in the output register while the next request is taken
module ordered_array_list_engine_unit #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_action,
    input  logic [3:0]  i_position,
    input  logic [31:0] i_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic        o_found,
    output logic [3:0]  o_found_position,
    output logic [31:0] o_read_value,
    output logic [4:0]  o_count
);

    logic             w_busy;
    logic             w_done;
    logic             w_take;
    oal_pkg::t_result w_result;

    logic             r_out_valid, n_out_valid;
    oal_pkg::t_result r_res;

    oal_seq #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_in_valid),
        .i_action   (i_action),
        .i_position (i_position),
        .i_value    (i_value),
        .o_busy     (w_busy),
        .o_done     (w_done),
        .i_take     (w_take),
        .o_result   (w_result)
    );

    assign o_in_stall = w_busy;
    assign w_take     = w_done && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_take) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_res <= w_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_res.status;
    assign o_found          = r_res.found;
    assign o_found_position = r_res.found_position;
    assign o_read_value     = r_res.read_value;
    assign o_count          = r_res.count;

    // accepted request keeps the input stalled while it is worked on
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepted request");

    a_take_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> o_out_valid)
        else $error("finished result not presented");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == oal_pkg::ST_FULL) |-> (o_count == 5'(CAPACITY)))
        else $error("list full reported below capacity");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (o_status == oal_pkg::ST_OK && o_count != 5'd0))
        else $error("search hit with bad status or empty list");

endmodule

/* tb/tb_top.sv */
// tb_top: self-checking bench for ordered_array_list_engine_unit, a table of directed requests
// then biased random grow/shrink traffic, results checked against table rows or a shadow list
// depends on oal_pkg and the engine rtl
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_ITEMS = 1300;

    typedef struct {
        oal_pkg::t_action act;
        logic [3:0]       pos;
        logic [31:0]      val;
        int               reps;
        bit               typed;
        oal_pkg::t_result want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [2:0]  i_action = '0;
    logic [3:0]  i_position = '0;
    logic [31:0] i_value = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_status;
    logic        o_found;
    logic [3:0]  o_found_position;
    logic [31:0] o_read_value;
    logic [4:0]  o_count;

    logic [31:0]      shadow_vals [CAPACITY];
    int               shadow_len = 0;
    oal_pkg::t_result pending_results [$];
    t_row             script [$];
    int               status_tally [4] = '{0, 0, 0, 0};
    int               search_hits = 0;
    int               sent_count = 0;
    int               checked_count = 0;
    int               fault_count = 0;
    bit               no_idle = 1'b0;

    ordered_array_list_engine_unit dut (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic oal_pkg::t_result make_result(oal_pkg::t_status st, logic hit,
                                                     logic [3:0] hit_pos, logic [31:0] rd,
                                                     logic [4:0] cnt);
        oal_pkg::t_result r;
        r.status         = st;
        r.found          = hit;
        r.found_position = hit_pos;
        r.read_value     = rd;
        r.count          = cnt;
        return r;
    endfunction

    function automatic string result_text(oal_pkg::t_result r);
        return $sformatf("status=%0d found=%0b fpos=%0d rdata=%08h count=%0d",
                         r.status, r.found, r.found_position, r.read_value, r.count);
    endfunction

    // shadow list update, returns the result the engine owes for this request
    function automatic oal_pkg::t_result apply_request(oal_pkg::t_action act, logic [3:0] pos,
                                                       logic [31:0] val);
        oal_pkg::t_result r;
        int               k;
        int               slot;
        r = make_result(oal_pkg::ST_OK, 1'b0, 4'd0, 32'd0, 5'd0);
        case (act)
            oal_pkg::ACT_INSERT_AT, oal_pkg::ACT_INSERT_LAST: begin
                slot = (act == oal_pkg::ACT_INSERT_AT) ? int'(pos) : shadow_len;
                if (shadow_len >= CAPACITY) begin
                    r.status = oal_pkg::ST_FULL;
                end else if (slot > shadow_len) begin
                    r.status = oal_pkg::ST_RANGE;
                end else begin
                    for (k = shadow_len; k > slot; k--) shadow_vals[k] = shadow_vals[k - 1];
                    shadow_vals[slot] = val;
                    shadow_len++;
                end
            end
            oal_pkg::ACT_DELETE_FIRST, oal_pkg::ACT_DELETE_AT, oal_pkg::ACT_DELETE_LAST: begin
                if (act == oal_pkg::ACT_DELETE_FIRST) slot = 0;
                else if (act == oal_pkg::ACT_DELETE_AT) slot = int'(pos);
                else slot = shadow_len - 1;
                if (shadow_len == 0) begin
                    r.status = oal_pkg::ST_EMPTY;
                end else if (slot >= shadow_len) begin
                    r.status = oal_pkg::ST_RANGE;
                end else begin
                    for (k = slot; k + 1 < shadow_len; k++) shadow_vals[k] = shadow_vals[k + 1];
                    shadow_len--;
                end
            end
            oal_pkg::ACT_SEARCH: begin
                for (k = 0; k < shadow_len; k++) begin
                    if (!r.found && shadow_vals[k] == val) begin
                        r.found          = 1'b1;
                        r.found_position = k[3:0];
                    end
                end
                if (r.found) search_hits++;
            end
            oal_pkg::ACT_READ, oal_pkg::ACT_MODIFY: begin
                if (shadow_len == 0) r.status = oal_pkg::ST_EMPTY;
                else if (int'(pos) >= shadow_len) r.status = oal_pkg::ST_RANGE;
                else if (act == oal_pkg::ACT_READ) r.read_value = shadow_vals[pos];
                else shadow_vals[pos] = val;
            end
            default: ;
        endcase
        r.count = shadow_len[4:0];
        status_tally[int'(r.status)]++;
        return r;
    endfunction

    task automatic offer_request(oal_pkg::t_action act, logic [3:0] pos, logic [31:0] val,
                                 bit typed, oal_pkg::t_result want);
        int               gap;
        oal_pkg::t_result owed;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_position <= pos;
        i_value    <= val;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        owed = apply_request(act, pos, val);
        pending_results.push_back(typed ? want : owed);
        sent_count++;
    endtask

    task automatic add_row(oal_pkg::t_action act, logic [3:0] pos, logic [31:0] val, int reps,
                           bit typed, oal_pkg::t_result want);
        t_row row;
        row.act   = act;
        row.pos   = pos;
        row.val   = val;
        row.reps  = reps;
        row.typed = typed;
        row.want  = want;
        script.push_back(row);
    endtask

    function automatic logic [31:0] draw_value();
        case ($urandom_range(0, 3))
            0: return 32'($urandom_range(0, 3));
            1: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            default: return $urandom;
        endcase
    endfunction

    function automatic oal_pkg::t_action draw_action(int ins_w, int del_w);
        int r;
        r = $urandom_range(0, 99);
        if (r < ins_w) begin
            return $urandom_range(0, 1) ? oal_pkg::ACT_INSERT_AT : oal_pkg::ACT_INSERT_LAST;
        end else if (r < ins_w + del_w) begin
            case ($urandom_range(0, 2))
                0: return oal_pkg::ACT_DELETE_FIRST;
                1: return oal_pkg::ACT_DELETE_AT;
                default: return oal_pkg::ACT_DELETE_LAST;
            endcase
        end
        case ($urandom_range(0, 2))
            0: return oal_pkg::ACT_SEARCH;
            1: return oal_pkg::ACT_READ;
            default: return oal_pkg::ACT_MODIFY;
        endcase
    endfunction

    initial begin : request_source
        oal_pkg::t_result none;
        oal_pkg::t_action act;
        logic [3:0]       pos;
        logic [31:0]      val;
        int               lim;
        int               ins_w;
        int               del_w;
        none = make_result(oal_pkg::ST_OK, 1'b0, 4'd0, 32'd0, 5'd0);

        add_row(oal_pkg::ACT_DELETE_FIRST, 4'd0, 32'd0, 1, 1'b1,
                make_result(oal_pkg::ST_EMPTY, 1'b0, 4'd0, 32'd0, 5'd0));
        add_row(oal_pkg::ACT_DELETE_AT, 4'd0, 32'd0, 1, 1'b1,
                make_result(oal_pkg::ST_EMPTY, 1'b0, 4'd0, 32'd0, 5'd0));
        add_row(oal_pkg::ACT_DELETE_LAST, 4'd0, 32'd0, 1, 1'b1,
                make_result(oal_pkg::ST_EMPTY, 1'b0, 4'd0, 32'd0, 5'd0));
        add_row(oal_pkg::ACT_READ, 4'd0, 32'd0, 1, 1'b1,
                make_result(oal_pkg::ST_EMPTY, 1'b0, 4'd0, 32'd0, 5'd0));
        add_row(oal_pkg::ACT_MODIFY, 4'd0, 32'hDEAD, 1, 1'b1,
                make_result(oal_pkg::ST_EMPTY, 1'b0, 4'd0, 32'd0, 5'd0));
        add_row(oal_pkg::ACT_SEARCH, 4'd0, 32'd0, 1, 1'b1,
                make_result(oal_pkg::ST_OK, 1'b0, 4'd0, 32'd0, 5'd0));
        add_row(oal_pkg::ACT_INSERT_AT, 4'd1, 32'd7, 1, 1'b1,
                make_result(oal_pkg::ST_RANGE, 1'b0, 4'd0, 32'd0, 5'd0));
        add_row(oal_pkg::ACT_INSERT_AT, 4'd0, 32'hFFFF_FFFF, 1, 1'b1,
                make_result(oal_pkg::ST_OK, 1'b0, 4'd0, 32'd0, 5'd1));
        add_row(oal_pkg::ACT_INSERT_LAST, 4'd9, 32'd0, 1, 1'b1,
                make_result(oal_pkg::ST_OK, 1'b0, 4'd0, 32'd0, 5'd2));
        add_row(oal_pkg::ACT_READ, 4'd1, 32'd0, 1, 1'b1,
                make_result(oal_pkg::ST_OK, 1'b0, 4'd0, 32'd0, 5'd2));
        add_row(oal_pkg::ACT_READ, 4'd0, 32'd0, 1, 1'b1,
                make_result(oal_pkg::ST_OK, 1'b0, 4'd0, 32'hFFFF_FFFF, 5'd2));
        add_row(oal_pkg::ACT_SEARCH, 4'd0, 32'd0, 1, 1'b1,
                make_result(oal_pkg::ST_OK, 1'b1, 4'd1, 32'd0, 5'd2));
        add_row(oal_pkg::ACT_INSERT_AT, 4'd15, 32'd1, 1, 1'b1,
                make_result(oal_pkg::ST_RANGE, 1'b0, 4'd0, 32'd0, 5'd2));
        add_row(oal_pkg::ACT_INSERT_LAST, 4'd0, 32'h8000_0000, 14, 1'b0, none);
        add_row(oal_pkg::ACT_INSERT_LAST, 4'd0, 32'd5, 1, 1'b1,
                make_result(oal_pkg::ST_FULL, 1'b0, 4'd0, 32'd0, 5'd16));
        add_row(oal_pkg::ACT_INSERT_AT, 4'd3, 32'd5, 1, 1'b1,
                make_result(oal_pkg::ST_FULL, 1'b0, 4'd0, 32'd0, 5'd16));
        add_row(oal_pkg::ACT_SEARCH, 4'd0, 32'h8000_000D, 1, 1'b0, none);
        add_row(oal_pkg::ACT_MODIFY, 4'd15, 32'h5555_AAAA, 1, 1'b0, none);
        add_row(oal_pkg::ACT_DELETE_AT, 4'd15, 32'd0, 1, 1'b0, none);
        add_row(oal_pkg::ACT_DELETE_AT, 4'd15, 32'd0, 1, 1'b1,
                make_result(oal_pkg::ST_RANGE, 1'b0, 4'd0, 32'd0, 5'd15));
        add_row(oal_pkg::ACT_DELETE_FIRST, 4'd0, 32'd0, 1, 1'b0, none);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i]) begin
            for (int n = 0; n < script[i].reps; n++) begin
                offer_request(script[i].act, script[i].pos, script[i].val + 32'(n),
                              script[i].typed, script[i].want);
            end
        end

        // alternate growing, shrinking and mixed traffic so the list swings between empty and full
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            no_idle = ((i / 150) % 5) == 3;
            case ((i / 60) % 3)
                0: begin ins_w = 60; del_w = 15; end
                1: begin ins_w = 15; del_w = 60; end
                default: begin ins_w = 30; del_w = 30; end
            endcase
            act = draw_action(ins_w, del_w);
            lim = (act == oal_pkg::ACT_INSERT_AT) ? shadow_len : shadow_len - 1;
            if (lim < 0 || $urandom_range(0, 9) == 0) pos = 4'($urandom_range(0, 15));
            else pos = 4'($urandom_range(0, (lim > 15) ? 15 : lim));
            if (act == oal_pkg::ACT_SEARCH && shadow_len > 0 && $urandom_range(0, 9) < 7)
                val = shadow_vals[$urandom_range(0, shadow_len - 1)];
            else
                val = draw_value();
            offer_request(act, pos, val, 1'b0, none);
        end
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("%0d requests sent, %0d results checked, %0d search hits", sent_count,
                 checked_count, search_hits);
        $display("refused: %0d full, %0d empty, %0d out of range",
                 status_tally[oal_pkg::ST_FULL], status_tally[oal_pkg::ST_EMPTY],
                 status_tally[oal_pkg::ST_RANGE]);
        if (fault_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // result side, with two long hold-offs to back the engine up
    initial begin : result_sink
        int hold;
        int taken;
        taken = 0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (taken == 300 || taken == 900) hold = 80;
            else hold = no_idle ? 0 : $urandom_range(0, 6);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            taken++;
        end
    end

    task automatic note_fault(string what);
        fault_count++;
        if (fault_count <= 10) $display("%0t: %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin
        oal_pkg::t_result want;
        oal_pkg::t_result got;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            got = make_result(oal_pkg::t_status'(o_status), o_found, o_found_position,
                              o_read_value, o_count);
            if (pending_results.size() == 0) begin
                note_fault($sformatf("unexpected result: %s", result_text(got)));
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.found !== want.found
                    || got.found_position !== want.found_position
                    || got.read_value !== want.read_value || got.count !== want.count) begin
                    note_fault($sformatf("result %0d: expected %s, got %s", checked_count,
                                         result_text(want), result_text(got)));
                end
                checked_count++;
            end
        end
    end

endmodule
